[src/pgpl_pkg.sv]
// Package for the presence-gated PIN lock: item classes, event codes,
// configuration indexes and reset values. Depends on nothing.
package pgpl_pkg;

    // Default number of code digits
    localparam int CODE_DIGITS_DEF = 4;

    // Field widths fixed by the interface
    localparam int TIME_W = 32;
    localparam int DIST_W = 16;
    localparam int KEY_W  = 4;
    localparam int EV_W   = 3;
    localparam int CNT_OUT_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIN_CODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_MAX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_TMO   = 2'd2;

    // Configuration reset values
    localparam logic [15:0]       PIN_CODE_RST  = 16'h1234;
    localparam logic [15:0]       PRES_MAX_RST  = 16'd500;
    localparam logic [TIME_W-1:0] PRES_TMO_RST  = 32'd15000;

    // Special input codes
    localparam logic [DIST_W-1:0] DIST_TIMEOUT = 16'hFFFF;
    localparam logic [KEY_W-1:0]  KEY_LAST_DIGIT = 4'd9;
    localparam logic [KEY_W-1:0]  KEY_C = 4'd12;
    localparam logic [KEY_W-1:0]  KEY_D = 4'd13;

    // Input item classes decided by the front end
    typedef enum logic [2:0] {
        OP_SAMPLE_NEAR,
        OP_SAMPLE_FAR,
        OP_KEY_DIGIT,
        OP_KEY_ENTER,
        OP_KEY_CLOSE,
        OP_KEY_OTHER
    } op_kind_t;

    // Classified item passed from front to back
    typedef struct packed {
        op_kind_t          kind;
        logic [TIME_W-1:0] now_ms;
        logic [KEY_W-1:0]  digit;
    } op_t;

    // Result event codes
    typedef enum logic [EV_W-1:0] {
        EV_NONE    = 3'd0,
        EV_BEEP    = 3'd1,
        EV_GRANTED = 3'd2,
        EV_DENIED  = 3'd3,
        EV_CLOSED  = 3'd4,
        EV_FIRST   = 3'd5,
        EV_IDLE    = 3'd6
    } event_t;

    // Result item
    typedef struct packed {
        event_t               event_res;
        logic                 present;
        logic [CNT_OUT_W-1:0] digits_entered;
    } result_t;

endpackage

[src/pgpl_queue.sv]
// Small register-based FIFO used between the front and back and on the result side.
// Depends on nothing.
module pgpl_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count update, wrapping at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[src/pgpl_front.sv]
// Front end of the lock: accepts input items and classifies them into operations.
// Depends on pgpl_pkg.
module pgpl_front (
    input  logic                        command,
    input  logic [pgpl_pkg::TIME_W-1:0] now_ms,
    input  logic [pgpl_pkg::DIST_W-1:0] distance_mm,
    input  logic [pgpl_pkg::KEY_W-1:0]  key_code,
    input  logic [15:0]                 near_max_mm,
    output pgpl_pkg::op_t               op
);
    import pgpl_pkg::*;

    logic near;

    // A sample counts as presence when valid and within range
    assign near = (distance_mm != DIST_TIMEOUT) && (distance_mm <= near_max_mm);

    // Classify the item
    always_comb
    begin
        op.now_ms = now_ms;
        op.digit  = key_code;
        if (!command)
        begin
            op.kind = near ? OP_SAMPLE_NEAR : OP_SAMPLE_FAR;
        end
        else if (key_code <= KEY_LAST_DIGIT)
        begin
            op.kind = OP_KEY_DIGIT;
        end
        else if (key_code == KEY_D)
        begin
            op.kind = OP_KEY_ENTER;
        end
        else if (key_code == KEY_C)
        begin
            op.kind = OP_KEY_CLOSE;
        end
        else
        begin
            op.kind = OP_KEY_OTHER;
        end
    end

endmodule

[src/pgpl_back.sv]
// Back end of the lock: holds presence and code state and executes one operation a cycle
// while op_valid is high. Depends on pgpl_pkg.
module pgpl_back #(
    parameter int CODE_DIGITS = pgpl_pkg::CODE_DIGITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        op_valid,
    input  pgpl_pkg::op_t               op,
    input  logic [15:0]                 pin_code,
    input  logic [pgpl_pkg::TIME_W-1:0] presence_timeout_ms,
    output pgpl_pkg::result_t           result
);
    import pgpl_pkg::*;

    localparam int BUF_W = 4 * CODE_DIGITS;
    localparam int CNT_W = $clog2(CODE_DIGITS + 1);

    logic              present_reg, present_next;
    logic              first_done_reg, first_done_next;
    logic [TIME_W-1:0] last_time_reg, last_time_next;
    logic [BUF_W-1:0]  code_reg, code_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    event_t            event_c;

    logic [TIME_W-1:0]    elapsed;
    logic                 timed_out;
    logic [BUF_W+3:0]     shifted;
    logic [BUF_W+15:0]    pin_ext;
    logic                 pin_match;
    logic                 buf_full;
    logic [CNT_W+2:0]     count_ext;

    // Time since last presence, modulo 2^32
    assign elapsed   = op.now_ms - last_time_reg;
    assign timed_out = elapsed > presence_timeout_ms;

    // Digit append and PIN compare at the configured code length
    assign shifted   = {code_reg, op.digit};
    assign pin_ext   = {{BUF_W{1'b0}}, pin_code};
    assign buf_full  = (count_reg == CNT_W'(CODE_DIGITS));
    assign pin_match = buf_full && (code_reg == pin_ext[BUF_W-1:0]);

    // Next state and event
    always_comb
    begin
        present_next    = present_reg;
        first_done_next = first_done_reg;
        last_time_next  = last_time_reg;
        code_next       = code_reg;
        count_next      = count_reg;
        event_c         = EV_NONE;
        case (op.kind)
            OP_SAMPLE_NEAR:
            begin
                present_next   = 1'b1;
                last_time_next = op.now_ms;
                if (!first_done_reg)
                begin
                    first_done_next = 1'b1;
                    event_c         = EV_FIRST;
                end
            end
            OP_SAMPLE_FAR:
            begin
                if (present_reg && timed_out)
                begin
                    present_next = 1'b0;
                    code_next    = '0;
                    count_next   = '0;
                    event_c      = EV_IDLE;
                end
            end
            OP_KEY_DIGIT:
            begin
                if (present_reg && !buf_full)
                begin
                    code_next  = shifted[BUF_W-1:0];
                    count_next = count_reg + 1'b1;
                    event_c    = EV_BEEP;
                end
            end
            OP_KEY_ENTER:
            begin
                if (present_reg)
                begin
                    code_next  = '0;
                    count_next = '0;
                    event_c    = pin_match ? EV_GRANTED : EV_DENIED;
                end
            end
            OP_KEY_CLOSE:
            begin
                if (present_reg)
                begin
                    code_next  = '0;
                    count_next = '0;
                    event_c    = EV_CLOSED;
                end
            end
            OP_KEY_OTHER:
            begin
                if (present_reg)
                begin
                    event_c = EV_BEEP;
                end
            end
            default:
            begin
                event_c = EV_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg    <= 1'b0;
            first_done_reg <= 1'b0;
            last_time_reg  <= '0;
            code_reg       <= '0;
            count_reg      <= '0;
        end
        else if (op_valid)
        begin
            present_reg    <= present_next;
            first_done_reg <= first_done_next;
            last_time_reg  <= last_time_next;
            code_reg       <= code_next;
            count_reg      <= count_next;
        end
    end

    // Result shows the state after this item; count keeps its low three bits
    assign count_ext             = {3'b000, count_next};
    assign result.event_res      = event_c;
    assign result.present        = present_next;
    assign result.digits_entered = count_ext[CNT_OUT_W-1:0];

endmodule

[src/presence_gated_pin_lock.sv]
// Top level of the presence-gated PIN lock: configuration registers, front end,
// operation queue, back end and result queue. Depends on pgpl_pkg and all pgpl_* modules.
//
//  Channel   Handshake                Payload
//  input     push / full              command, now_ms, distance_mm, key_code
//  result    empty / pop              event_res, present, digits_entered
//  config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One item enters per cycle unless full, one result leaves per cycle unless empty; the
// back end executes one operation a cycle while the result queue has room, moving it
// from the operation queue to the result queue. Each side stalls on its own through a
// two-entry queue; full rises only once results are not popped and both queues fill up.
// Reset is asynchronous and active low; it clears state and loads register defaults.
module presence_gated_pin_lock #(
    parameter int CODE_DIGITS = pgpl_pkg::CODE_DIGITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           command,
    input  logic [pgpl_pkg::TIME_W-1:0]    now_ms,
    input  logic [pgpl_pkg::DIST_W-1:0]    distance_mm,
    input  logic [pgpl_pkg::KEY_W-1:0]     key_code,
    output logic                           empty,
    input  logic                           pop,
    output logic [pgpl_pkg::EV_W-1:0]      event_res,
    output logic                           present,
    output logic [pgpl_pkg::CNT_OUT_W-1:0] digits_entered,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pgpl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pgpl_pkg::CFG_DAT_W-1:0] cfg_data
);
    import pgpl_pkg::*;

    localparam int OP_W  = $bits(op_t);
    localparam int RES_W = $bits(result_t);

    logic [15:0]       pin_code_reg;
    logic [15:0]       pres_max_reg;
    logic [TIME_W-1:0] pres_tmo_reg;

    op_t              front_op;
    logic [OP_W-1:0]  mid_data;
    op_t              back_op;
    logic             mid_empty;
    logic             res_full;
    logic             step;
    result_t          back_res;
    logic [RES_W-1:0] res_data;
    result_t          out_res;

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_code_reg <= PIN_CODE_RST;
            pres_max_reg <= PRES_MAX_RST;
            pres_tmo_reg <= PRES_TMO_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PIN_CODE: pin_code_reg <= cfg_data[15:0];
                CFG_PRES_MAX: pres_max_reg <= cfg_data[15:0];
                CFG_PRES_TMO: pres_tmo_reg <= cfg_data;
                default:      pin_code_reg <= pin_code_reg;
            endcase
        end
    end

    // Front end classifies the incoming item
    pgpl_front u_front (
        .command     (command),
        .now_ms      (now_ms),
        .distance_mm (distance_mm),
        .key_code    (key_code),
        .near_max_mm (pres_max_reg),
        .op          (front_op)
    );

    // Queue of classified operations
    pgpl_queue #(
        .WIDTH (OP_W),
        .DEPTH (2)
    ) u_op_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_op),
        .full    (full),
        .pop     (step),
        .rd_data (mid_data),
        .empty   (mid_empty)
    );

    // Back end runs whenever an operation waits and the result queue has room
    assign back_op = op_t'(mid_data);
    assign step    = !mid_empty && !res_full;

    pgpl_back #(
        .CODE_DIGITS (CODE_DIGITS)
    ) u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .op_valid            (step),
        .op                  (back_op),
        .pin_code            (pin_code_reg),
        .presence_timeout_ms (pres_tmo_reg),
        .result              (back_res)
    );

    // Result queue towards the consumer
    pgpl_queue #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (step),
        .wr_data (back_res),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_data),
        .empty   (empty)
    );

    assign out_res        = result_t'(res_data);
    assign event_res      = out_res.event_res;
    assign present        = out_res.present;
    assign digits_entered = out_res.digits_entered;

endmodule

[test/presence_gated_pin_lock_tb.sv]
// Self-checking testbench for presence_gated_pin_lock: directed table, then randomised visits
// checked against an in-bench predictor of the lock, with random idling on both queues.
// Depends on pgpl_pkg and the presence_gated_pin_lock RTL.
module presence_gated_pin_lock_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pgpl_pkg::*;

    localparam int NDIG = CODE_DIGITS_DEF;
    localparam logic [31:0] CODE_MASK =
        (NDIG >= 8) ? 32'hFFFF_FFFF : ((32'd1 << (4 * NDIG)) - 32'd1);

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_KEY    = 1'b1;

    localparam logic [KEY_W-1:0] KEY_A    = 4'd10;
    localparam logic [KEY_W-1:0] KEY_STAR = 4'd14;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int ITEMS_TOTAL  = 1450;
    localparam int PHASES       = 8;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int SETTLE_TICKS = 8;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic                 command;
    logic [TIME_W-1:0]    now_ms;
    logic [DIST_W-1:0]    distance_mm;
    logic [KEY_W-1:0]     key_code;
    logic                 empty;
    logic                 pop;
    logic [EV_W-1:0]      event_res;
    logic                 present;
    logic [CNT_OUT_W-1:0] digits_entered;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // Mirror of the lock's registers and state
    logic [15:0] pin_now;
    logic [15:0] near_limit;
    logic [31:0] idle_after;
    logic        someone_here;
    logic [31:0] last_seen_ms;
    logic [31:0] code_held;
    logic [3:0]  digits_held;
    logic        greeted;

    result_t lock_events_due[$];
    int      faults = 0;
    int      items_counted;
    int      cycles = 0;
    bit      steady;
    logic [31:0] t_ms;

    // One row of the directed table
    typedef struct {
        logic        cmd;
        logic [31:0] t;
        logic [15:0] d;
        logic [3:0]  k;
        bit          typed;
        event_t      ev;
        logic        pres;
        logic [2:0]  cnt;
    } probe_t;

    probe_t plan[$];

    presence_gated_pin_lock uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .command        (command),
        .now_ms         (now_ms),
        .distance_mm    (distance_mm),
        .key_code       (key_code),
        .empty          (empty),
        .pop            (pop),
        .event_res      (event_res),
        .present        (present),
        .digits_entered (digits_entered),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Advances the mirrored lock by one item and returns the event it should report.
    function automatic result_t lock_next_result(logic cmd, logic [31:0] t, logic [15:0] d,
                                                 logic [3:0] k);
        event_t  ev;
        result_t r;
        ev = EV_NONE;
        if (cmd == CMD_SAMPLE)
        begin
            if (d != DIST_TIMEOUT && d <= near_limit)
            begin
                someone_here = 1'b1;
                last_seen_ms = t;
                if (!greeted)
                begin
                    greeted = 1'b1;
                    ev = EV_FIRST;
                end
            end
            else if (someone_here && (t - last_seen_ms) > idle_after)
            begin
                someone_here = 1'b0;
                code_held = '0;
                digits_held = '0;
                ev = EV_IDLE;
            end
        end
        else if (someone_here)
        begin
            if (k <= KEY_LAST_DIGIT)
            begin
                // A digit on a full buffer is dropped silently.
                if (digits_held < NDIG)
                begin
                    code_held = ((code_held << 4) | 32'(k)) & CODE_MASK;
                    digits_held = digits_held + 4'd1;
                    ev = EV_BEEP;
                end
            end
            else if (k == KEY_D)
            begin
                if (digits_held == NDIG && code_held == ({16'd0, pin_now} & CODE_MASK))
                    ev = EV_GRANTED;
                else
                    ev = EV_DENIED;
                code_held = '0;
                digits_held = '0;
            end
            else if (k == KEY_C)
            begin
                code_held = '0;
                digits_held = '0;
                ev = EV_CLOSED;
            end
            else
                ev = EV_BEEP;
        end
        r.event_res = ev;
        r.present = someone_here;
        r.digits_entered = digits_held[2:0];
        return r;
    endfunction

    function automatic void plan_row(logic cmd, logic [31:0] t, logic [15:0] d, logic [3:0] k,
                                     bit typed, event_t ev, logic pres, logic [2:0] cnt);
        probe_t p;
        p.cmd = cmd;
        p.t = t;
        p.d = d;
        p.k = k;
        p.typed = typed;
        p.ev = ev;
        p.pres = pres;
        p.cnt = cnt;
        plan.push_back(p);
    endfunction

    // Offers one item after a random gap and records its expected result once taken.
    task automatic send_item(input logic cmd, input logic [31:0] t, input logic [15:0] d,
                             input logic [3:0] k, input bit typed, input result_t typed_res);
        int      gap;
        bit      counts;
        result_t r;
        gap = steady ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap > 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        push = 1'b1;
        command = cmd;
        now_ms = t;
        distance_mm = d;
        key_code = k;
        do @(posedge clk); while (full !== 1'b0);
        // Keys while nobody is present are ignored and do not count.
        counts = !(cmd == CMD_KEY && !someone_here);
        r = lock_next_result(cmd, t, d, k);
        if (typed)
            r = typed_res;
        lock_events_due.push_back(r);
        if (counts)
            items_counted++;
    endtask

    task automatic send_sample(input logic [31:0] t, input logic [15:0] d);
        send_item(CMD_SAMPLE, t, d, 4'($urandom_range(0, 15)), 1'b0, '0);
    endtask

    task automatic send_key(input logic [3:0] k);
        send_item(CMD_KEY, $urandom, 16'($urandom_range(0, 65535)), k, 1'b0, '0);
    endtask

    function automatic logic [15:0] near_dist();
        return (near_limit == 16'd0) ? 16'd0 : 16'($urandom_range(0, near_limit));
    endfunction

    function automatic logic [15:0] far_dist();
        if (near_limit >= 16'hFFFE || $urandom_range(0, 1) == 0)
            return DIST_TIMEOUT;
        return 16'($urandom_range(near_limit + 1, 65534));
    endfunction

    // Stops sending and waits until every expected result has been taken.
    task automatic wait_drained();
        @(negedge clk);
        push = 1'b0;
        while (lock_events_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (idx)
            CFG_PIN_CODE: pin_now = data[15:0];
            CFG_PRES_MAX: near_limit = data[15:0];
            CFG_PRES_TMO: idle_after = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // One person's visit: approach, key in a code, then usually walk away.
    task automatic run_visit();
        int         n;
        bit         right;
        logic [3:0] dg;
        steady = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 15) == 0)
            t_ms = 32'hFFFF_FFFF - $urandom_range(0, 400);
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 6))
                send_item(1'($urandom_range(0, 1)), $urandom, 16'($urandom_range(0, 65535)),
                          4'($urandom_range(0, 15)), 1'b0, '0);
        end
        t_ms = t_ms + $urandom_range(1, 300);
        send_sample(t_ms, near_dist());
        repeat ($urandom_range(0, 2))
        begin
            t_ms = t_ms + $urandom_range(0, 100);
            if ($urandom_range(0, 3) == 0)
                send_sample(t_ms, far_dist());
            else
                send_sample(t_ms, near_dist());
        end
        case ($urandom_range(0, 5))
            0: n = NDIG - 1;
            1: n = NDIG + 1;
            default: n = NDIG;
        endcase
        right = ($urandom_range(0, 2) != 0);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_key((($urandom_range(0, 1) == 0) ? KEY_A : KEY_STAR) +
                         4'($urandom_range(0, 1)));
            if (right && i < NDIG)
                dg = 4'(({16'd0, pin_now} >> (4 * (NDIG - 1 - i))) & 32'hF);
            else
                dg = 4'($urandom_range(0, 9));
            send_key(dg);
        end
        case ($urandom_range(0, 9))
            7, 8: send_key(KEY_C);
            9: ;
            default: send_key(KEY_D);
        endcase
        // Leaving: far samples placed on and around the idle boundary.
        if ($urandom_range(0, 4) != 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                case ($urandom_range(0, 3))
                    0: t_ms = last_seen_ms + idle_after;
                    1: t_ms = last_seen_ms + idle_after + 32'd1;
                    2: t_ms = t_ms + $urandom_range(0, 1000);
                    default: t_ms = $urandom;
                endcase
                send_sample(t_ms, far_dist());
            end
            if ($urandom_range(0, 2) == 0)
                send_key(4'($urandom_range(0, 15)));
        end
    endtask

    // Result side: random stalls, each taken result checked against the oldest expectation.
    initial
    begin
        int      stall;
        result_t want;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 7);
            @(negedge clk);
            if (stall > 0)
            begin
                pop = 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop = 1'b1;
            do @(posedge clk); while (empty !== 1'b0);
            if (lock_events_due.size() == 0)
            begin
                $display("%0t: unexpected result: event_res %0d, present %0d, digits_entered %0d",
                         $time, event_res, present, digits_entered);
                faults++;
            end
            else
            begin
                want = lock_events_due.pop_front();
                if (event_res !== want.event_res)
                begin
                    $display("%0t: event_res expected %0d, got %0d",
                             $time, want.event_res, event_res);
                    faults++;
                end
                if (present !== want.present)
                begin
                    $display("%0t: present expected %0d, got %0d", $time, want.present, present);
                    faults++;
                end
                if (digits_entered !== want.digits_entered)
                begin
                    $display("%0t: digits_entered expected %0d, got %0d",
                             $time, want.digits_entered, digits_entered);
                    faults++;
                end
            end
        end
    end

    // Sender side: reset, directed table, then randomised phases under different settings.
    initial
    begin
        result_t     typed_res;
        logic [15:0] pin_set;
        logic [15:0] max_set;
        logic [31:0] tmo_set;
        rst_n = 1'b0;
        push = 1'b0;
        command = CMD_SAMPLE;
        now_ms = '0;
        distance_mm = '0;
        key_code = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PIN_CODE;
        cfg_data = '0;
        items_counted = 0;
        steady = 1'b0;
        t_ms = '0;
        pin_now = PIN_CODE_RST;
        near_limit = PRES_MAX_RST;
        idle_after = PRES_TMO_RST;
        someone_here = 1'b0;
        last_seen_ms = '0;
        code_held = '0;
        digits_held = '0;
        greeted = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table, with the reset settings in force
        plan_row(CMD_KEY,    32'd0,     16'd0,        KEY_C, 1, EV_NONE,    1'b0, 3'd0);
        plan_row(CMD_SAMPLE, 32'd0,     DIST_TIMEOUT, 4'd0,  1, EV_NONE,    1'b0, 3'd0);
        plan_row(CMD_SAMPLE, 32'd10,    16'd501,      4'd0,  1, EV_NONE,    1'b0, 3'd0);
        plan_row(CMD_SAMPLE, 32'd100,   16'd500,      4'd0,  1, EV_FIRST,   1'b1, 3'd0);
        plan_row(CMD_SAMPLE, 32'd200,   16'd0,        4'd0,  1, EV_NONE,    1'b1, 3'd0);
        plan_row(CMD_KEY,    32'hFFFF_FFFF, 16'hFFFF, 4'd0,  0, EV_NONE,    1'b0, 3'd0);
        plan_row(CMD_KEY,    32'd0,     16'd0,        4'd9,  0, EV_NONE,    1'b0, 3'd0);
        plan_row(CMD_KEY,    32'd0,     16'd0,        KEY_D, 1, EV_DENIED,  1'b1, 3'd0);
        plan_row(CMD_KEY,    32'd0,     16'd0,        4'd1,  0, EV_NONE,    1'b0, 3'd0);
        plan_row(CMD_KEY,    32'd0,     16'd0,        4'd2,  0, EV_NONE,    1'b0, 3'd0);
        plan_row(CMD_KEY,    32'd0,     16'd0,        4'd3,  0, EV_NONE,    1'b0, 3'd0);
        plan_row(CMD_KEY,    32'd0,     16'd0,        4'd4,  0, EV_NONE,    1'b0, 3'd0);
        plan_row(CMD_KEY,    32'd0,     16'd0,        4'd9,  1, EV_NONE,    1'b1, 3'd4);
        plan_row(CMD_KEY,    32'd0,     16'd0,        KEY_D, 1, EV_GRANTED, 1'b1, 3'd0);
        plan_row(CMD_KEY,    32'd0,     16'd0,        KEY_A, 0, EV_NONE,    1'b0, 3'd0);
        plan_row(CMD_KEY,    32'd0,     16'd0,        4'd11, 0, EV_NONE,    1'b0, 3'd0);
        plan_row(CMD_KEY,    32'd0,     16'd0,        KEY_STAR, 0, EV_NONE, 1'b0, 3'd0);
        plan_row(CMD_KEY,    32'd0,     16'd0,        4'd15, 0, EV_NONE,    1'b0, 3'd0);
        plan_row(CMD_KEY,    32'd0,     16'd0,        4'd7,  0, EV_NONE,    1'b0, 3'd0);
        plan_row(CMD_KEY,    32'd0,     16'd0,        KEY_C, 1, EV_CLOSED,  1'b1, 3'd0);
        plan_row(CMD_KEY,    32'd0,     16'd0,        4'd3,  0, EV_NONE,    1'b0, 3'd0);
        // Exactly on the timeout stays present; one millisecond more goes idle.
        plan_row(CMD_SAMPLE, 32'd15200, DIST_TIMEOUT, 4'd0,  1, EV_NONE,    1'b1, 3'd1);
        plan_row(CMD_SAMPLE, 32'd15201, 16'd65534,    4'd0,  1, EV_IDLE,    1'b0, 3'd0);
        plan_row(CMD_SAMPLE, 32'd40000, DIST_TIMEOUT, 4'd0,  1, EV_NONE,    1'b0, 3'd0);
        plan_row(CMD_KEY,    32'd0,     16'd0,        KEY_D, 1, EV_NONE,    1'b0, 3'd0);
        // A later detection is not reported again; elapsed time wraps around zero.
        plan_row(CMD_SAMPLE, 32'hFFFF_FF00, 16'd1,    4'd0,  1, EV_NONE,    1'b1, 3'd0);
        plan_row(CMD_SAMPLE, 32'h0000_3000, DIST_TIMEOUT, 4'd0, 0, EV_NONE, 1'b0, 3'd0);

        foreach (plan[i])
        begin
            typed_res.event_res = plan[i].ev;
            typed_res.present = plan[i].pres;
            typed_res.digits_entered = plan[i].cnt;
            send_item(plan[i].cmd, plan[i].t, plan[i].d, plan[i].k, plan[i].typed, typed_res);
        end
        t_ms = 32'h0000_3000;

        // Random phases, each under its own register settings
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            if (p > 0)
            begin
                case (p)
                    1: begin pin_set = 16'h0000; max_set = 16'd0; tmo_set = 32'd0; end
                    2: begin pin_set = 16'hFFFF; max_set = 16'hFFFE; tmo_set = 32'hFFFF_FFFF; end
                    3: begin pin_set = 16'h9876; max_set = 16'd1000; tmo_set = 32'd50; end
                    4:
                    begin
                        pin_set = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                                   4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
                        max_set = 16'($urandom_range(0, 65534));
                        tmo_set = $urandom_range(0, 300);
                    end
                    5:
                    begin
                        pin_set = 16'($urandom);
                        max_set = 16'($urandom_range(0, 65534));
                        tmo_set = $urandom;
                    end
                    6:
                    begin
                        pin_set = PIN_CODE_RST;
                        max_set = PRES_MAX_RST;
                        tmo_set = PRES_TMO_RST;
                    end
                    default:
                    begin
                        pin_set = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                                   4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
                        max_set = 16'hFFFE;
                        tmo_set = 32'd1;
                    end
                endcase
                // Upper data bits of the 16-bit registers are to be dropped.
                write_reg(CFG_PIN_CODE, {16'($urandom), pin_set});
                write_reg(CFG_PRES_MAX, {16'($urandom), max_set});
                write_reg(CFG_PRES_TMO, tmo_set);
                if (p == 3)
                    write_reg(CFG_UNUSED, $urandom);
            end
            while (items_counted < ((p + 1) * ITEMS_TOTAL) / PHASES)
                run_visit();
        end

        wait_drained();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (faults == 0 && lock_events_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
